[src/i2a_pkg.sv]
`timescale 1ns / 1ps

package i2a_pkg;

  // Width of the value port and the number of its bits that carry the number
  localparam int VALUE_W    = 64;
  localparam int VALUE_BITS = 64;

  // Digit counts: hex digits of the full word, decimal digits of 2^(VALUE_BITS-1)
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DEC_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_W      = 4 * NDIG;
  localparam int CNT_W      = $clog2(NDIG + 1);
  localparam int BIT_W      = $clog2(VALUE_BITS);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_HEX,
    OP_LOAD_DEC,
    OP_DABBLE,
    OP_SHIFT
  } op_t;

  typedef struct packed {
    logic [3:0] top;
    logic       top_zero;
  } dig_stat_t;

  // Map one digit to its ASCII character
  function automatic logic [7:0] char_of(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? CH_UPPER : CH_LOWER;
    if (d < 4'd10) begin
      char_of = CH_ZERO + {4'd0, d};
    end else begin
      char_of = base + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

[src/i2a_digit_unit.sv]
`timescale 1ns / 1ps

module i2a_digit_unit (
  input  logic                          clk,
  input  i2a_pkg::op_t                  op,
  input  logic [i2a_pkg::VALUE_W-1:0]   value,
  output i2a_pkg::dig_stat_t            stat
);
  import i2a_pkg::*;

  logic [DIG_W-1:0]      digs;
  logic [DIG_W-1:0]      digs_next;
  logic [VALUE_BITS-1:0] bin;
  logic [VALUE_BITS-1:0] bin_next;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [DIG_W-1:0]      adj;

  // Take the magnitude of the two's complement number
  assign raw = value[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  // Add three to every BCD digit of five or more
  always_comb begin
    logic [3:0] nib;
    nib = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      nib = digs[4*i +: 4];
      adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  // Select the next digit word and binary shift register
  always_comb begin
    digs_next = digs;
    bin_next  = bin;
    unique case (op)
      OP_HOLD: begin
      end
      OP_LOAD_HEX: begin
        digs_next = DIG_W'(raw);
      end
      OP_LOAD_DEC: begin
        digs_next = '0;
        bin_next  = mag;
      end
      OP_DABBLE: begin
        digs_next = {adj[DIG_W-2:0], bin[VALUE_BITS-1]};
        bin_next  = bin << 1;
      end
      OP_SHIFT: begin
        digs_next = digs << 4;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    digs <= digs_next;
    bin  <= bin_next;
  end

  assign stat.top      = digs[DIG_W-1 -: 4];
  assign stat.top_zero = (digs[DIG_W-1 -: 4] == 4'd0);

endmodule

[src/i2a_ctrl.sv]
`timescale 1ns / 1ps

module i2a_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic               value_sign,
  input  logic               upper_case,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         char_out,
  output logic               last,
  output i2a_pkg::op_t       op,
  input  i2a_pkg::dig_stat_t stat
);
  import i2a_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [BIT_W-1:0] bitcnt;
  logic [BIT_W-1:0] bitcnt_next;
  logic             up;
  logic             neg;
  logic             slot;
  logic             load_out;
  logic [7:0]       ch_next;
  logic             last_next;

  // Output register is free when empty or being drained this cycle
  assign slot = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    bitcnt <= bitcnt_next;
    if (in_valid && in_ready) begin
      up  <= upper_case;
      neg <= !req_type && value_sign;
    end
    if (load_out) begin
      char_out <= ch_next;
      last     <= last_next;
    end
  end

  // Sequence: convert, drop leading zeros, emit sign and digits
  always_comb begin
    state_next  = state;
    op          = OP_HOLD;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    ch_next     = CH_ZERO;
    last_next   = 1'b0;
    cnt_next    = cnt;
    bitcnt_next = bitcnt;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          cnt_next    = CNT_W'(NDIG);
          bitcnt_next = '0;
          if (req_type) begin
            op         = OP_LOAD_HEX;
            state_next = ST_SKIP;
          end else begin
            op         = OP_LOAD_DEC;
            state_next = ST_DABBLE;
          end
        end
      end
      ST_DABBLE: begin
        op          = OP_DABBLE;
        bitcnt_next = bitcnt + BIT_W'(1);
        if (bitcnt == BIT_W'(VALUE_BITS - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && cnt > CNT_W'(1)) begin
          op       = OP_SHIFT;
          cnt_next = cnt - CNT_W'(1);
        end else begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot) begin
          load_out   = 1'b1;
          ch_next    = CH_MINUS;
          last_next  = 1'b0;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot) begin
          load_out  = 1'b1;
          ch_next   = char_of(stat.top, up);
          last_next = (cnt == CNT_W'(1));
          op        = OP_SHIFT;
          cnt_next  = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/integer_to_ascii_digits.sv]
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_ready  req_type, value[63:0], upper_case
// out      out_valid/ out_ready char_out[7:0], last
//
// Hex: the value is loaded, leading zero digits are dropped over the 19
// digit positions, the drop loop is left, then the characters are emitted.
// Decimal: the value is loaded and converted by shift-and-add-3 through the
// shared digit register, then the same drop and emit follow, with a minus
// sign emitted before the digits when the value is negative.
// in_ready is high only in idle outside reset. rst (synchronous) returns to
// idle and empties the output register. A stalled output holds the character
// and holds the emit sequence until the character is taken.
module integer_to_ascii_digits (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [i2a_pkg::VALUE_W-1:0] value,
  input  logic                        upper_case,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  char_out,
  output logic                        last
);
  import i2a_pkg::*;

  op_t       op;
  dig_stat_t stat;

  i2a_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .value_sign (value[VALUE_BITS-1]),
    .upper_case (upper_case),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .last       (last),
    .op         (op),
    .stat       (stat)
  );

  i2a_digit_unit u_digit (
    .clk   (clk),
    .op    (op),
    .value (value),
    .stat  (stat)
  );

endmodule

[src/i2a_checker.sv]
`timescale 1ns / 1ps

module i2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_out,
  input logic       last
);
  import i2a_pkg::*;

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last))
    else $error("output beat changed while stalled");

  // Accepting a number makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  // A pending non-final character means the number is still in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("ready while a number is partly emitted");

  // Only sign and digit characters appear
  a_charset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_out == CH_MINUS) ||
                  (char_out >= CH_ZERO && char_out <= CH_ZERO + 8'd9) ||
                  (char_out >= CH_UPPER && char_out <= CH_UPPER + 8'd5) ||
                  (char_out >= CH_LOWER && char_out <= CH_LOWER + 8'd5))
    else $error("unexpected character");

endmodule

bind integer_to_ascii_digits i2a_checker u_i2a_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .char_out  (char_out),
  .last      (last)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import i2a_pkg::*;

  localparam logic REQ_DEC  = 1'b0;
  localparam logic REQ_HEX  = 1'b1;
  localparam logic LOWER    = 1'b0;
  localparam logic UPPER    = 1'b1;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 200;

  // One directed row: the expected text is right aligned, all zero when predicted
  typedef struct packed {
    logic         hex;
    logic [63:0]  num;
    logic         up;
    logic [159:0] text;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_beat_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{REQ_DEC, 64'd0,                  LOWER, "0"},
    '{REQ_HEX, 64'd0,                  UPPER, "0"},
    '{REQ_DEC, 64'h8000_0000_0000_0000, LOWER, "-9223372036854775808"},
    '{REQ_DEC, 64'h7FFF_FFFF_FFFF_FFFF, LOWER, "9223372036854775807"},
    '{REQ_DEC, 64'hFFFF_FFFF_FFFF_FFFF, LOWER, "-1"},
    '{REQ_DEC, 64'hFFFF_FFFF_FFFF_FFFF, UPPER, "-1"},
    '{REQ_HEX, 64'hFFFF_FFFF_FFFF_FFFF, UPPER, "FFFFFFFFFFFFFFFF"},
    '{REQ_HEX, 64'hFFFF_FFFF_FFFF_FFFF, LOWER, "ffffffffffffffff"},
    '{REQ_HEX, 64'h8000_0000_0000_0000, LOWER, "8000000000000000"},
    '{REQ_HEX, 64'h7FFF_FFFF_FFFF_FFFF, UPPER, "7FFFFFFFFFFFFFFF"},
    '{REQ_DEC, 64'd1,                  LOWER, "1"},
    '{REQ_HEX, 64'd1,                  LOWER, "1"},
    '{REQ_DEC, 64'd9,                  UPPER, "9"},
    '{REQ_DEC, 64'd10,                 LOWER, "10"},
    '{REQ_DEC, 64'hFFFF_FFFF_FFFF_FFF6, LOWER, "-10"},
    '{REQ_HEX, 64'h0123_4567_89AB_CDEF, UPPER, "123456789ABCDEF"},
    '{REQ_HEX, 64'h0123_4567_89AB_CDEF, LOWER, "123456789abcdef"},
    '{REQ_HEX, 64'h0000_0000_0000_000A, LOWER, "a"},
    '{REQ_HEX, 64'h0000_0000_0000_00F0, UPPER, "F0"},
    '{REQ_DEC, 64'd999999999999999999, LOWER, 160'd0},
    '{REQ_DEC, 64'hDEAD_BEEF_0BAD_F00D, UPPER, 160'd0},
    '{REQ_HEX, 64'h5A5A_0000_0000_A5A5, UPPER, 160'd0}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               req_type;
  logic [VALUE_W-1:0] value;
  logic               upper_case;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         char_out;
  logic               last;

  char_beat_t chars_due [$];
  char_beat_t want;
  int         mismatch_count = 0;
  bit         quiet = 1'b0;
  bit         long_hold_req = 1'b0;

  integer_to_ascii_digits DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .value      (value),
    .upper_case (upper_case),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .last       (last)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Expand one number into the characters it should produce, most significant first
  function automatic void predict_digits(input logic hex, input logic [63:0] raw,
                                         input logic up);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] sign;
    logic [3:0]  d;
    logic [7:0]  rev [0:19];
    int          nrev;
    logic        neg;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    v    = raw & mask;
    nrev = 0;
    neg  = 1'b0;
    if (hex) begin
      do begin
        d = v[3:0];
        rev[nrev] = (d < 4'd10) ? CH_ZERO + {4'd0, d}
                                : (up ? CH_UPPER : CH_LOWER) + {4'd0, d - 4'd10};
        nrev++;
        v = v >> 4;
      end while (v != 64'd0);
    end else begin
      sign = 64'd1 << (VALUE_BITS - 1);
      if ((v & sign) != 64'd0) begin
        neg = 1'b1;
        v   = (~v + 64'd1) & mask;
      end
      do begin
        rev[nrev] = CH_ZERO + 8'(v % 64'd10);
        nrev++;
        v = v / 64'd10;
      end while (v != 64'd0);
    end
    if (neg) chars_due.push_back('{CH_MINUS, 1'b0});
    for (int k = nrev - 1; k >= 0; k--) chars_due.push_back('{rev[k], k == 0});
  endfunction

  // Queue a literal string; the rightmost byte is the final character
  function automatic void push_literal(input logic [159:0] text);
    logic [7:0] c;
    for (int k = 19; k >= 0; k--) begin
      c = text[k*8 +: 8];
      if (c != 8'd0) chars_due.push_back('{c, k == 0});
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick values spread over magnitudes, signs and the sign boundary
  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    int          k;
    case ($urandom_range(0, 9))
      0, 1, 2: return {$urandom, $urandom};
      3:       return 64'($urandom_range(0, 20));
      4:       return -64'($urandom_range(1, 20));
      5:       return {$urandom, $urandom} >> $urandom_range(0, 63);
      6: begin
        if ($urandom_range(0, 1)) return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
        return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      end
      7: begin
        p = 64'd1;
        k = $urandom_range(0, 18);
        repeat (k) p = p * 64'd10;
        p = p + 64'($urandom_range(0, 2)) - 64'd1;
        return $urandom_range(0, 1) ? p : -p;
      end
      8: begin
        p = 64'd1 << $urandom_range(0, 63);
        return $urandom_range(0, 1) ? p : -p;
      end
      default: return {1'b1, 31'($urandom), $urandom};
    endcase
  endfunction

  // Offer one number and hold it until accepted; returns at the accepting edge
  task automatic offer_number(input logic hex, input logic [63:0] num, input logic up,
                              input logic [159:0] text);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= hex;
    value      <= num;
    upper_case <= up;
    do @(posedge clk); while (!in_ready);
    if (text != 160'd0) push_literal(text);
    else predict_digits(hex, num, up);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
  endtask

  task automatic offer_random(input int count);
    for (int n = 0; n < count; n++) begin
      offer_number(1'($urandom_range(0, 1)), pick_value(), 1'($urandom_range(0, 1)),
                   160'd0);
    end
  endtask

  // Stimulus
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_DEC;
    value      = '0;
    upper_case = LOWER;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_number(DIR_TAB[i].hex, DIR_TAB[i].num, DIR_TAB[i].up, DIR_TAB[i].text);
    end
    drain_results();

    // Back to back with the receiver always ready
    quiet = 1'b1;
    offer_random(50);
    drain_results();
    quiet = 1'b0;

    // Hold the receiver off while numbers keep coming
    long_hold_req = 1'b1;
    offer_random(40);
    drain_results();

    for (int blk = 0; blk < 6; blk++) begin
      offer_random(20);
      if (blk % 3 == 2) drain_results();
    end

    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random ready runs and gaps, quiet stretches, one long hold-off
  initial begin
    int run;
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Compare each output beat with the oldest expected character
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (chars_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected char 0x%02h last=%0b", char_out, last));
      end else begin
        want = chars_due.pop_front();
        if (char_out !== want.ch || last !== want.fin) begin
          flag_mismatch($sformatf("got char 0x%02h last=%0b, want char 0x%02h last=%0b",
                                  char_out, last, want.ch, want.fin));
        end
      end
    end
  end

  // Timeout
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
